@@ hw/rtl/sfd_pkg.sv @@
package sfd_pkg;

   // fixed flat limit used for screen-up calibration, 0.7 g in Q4.12
   localparam logic [15:0] FLAT_CAL_LIMIT = 16'd2867;

   localparam int DIFF_W = 17;
   localparam int DSQ_W  = 34;
   localparam int TSQ_W  = 30;

   typedef enum logic [2:0] {
      CSR_SHAKE_THRESHOLD      = 3'd0,
      CSR_DOMINANT_Z_THRESHOLD = 3'd1,
      CSR_FLAT_AXIS_THRESHOLD  = 3'd2,
      CSR_WAKE_Z_THRESHOLD     = 3'd3,
      CSR_SHAKE_COOLDOWN_MS    = 3'd4,
      CSR_DIZZY_DURATION_MS    = 3'd5,
      CSR_FACE_DOWN_HOLD_MS    = 3'd6,
      CSR_FACE_UP_HOLD_MS      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        now_ms;
      logic               external_wake;
   } req_type;

   typedef struct packed {
      logic        shake_detected;
      logic [31:0] dizzy_until_ms;
      logic        face_down_sleep;
      logic        sleep_entered;
      logic        sleep_cleared;
      logic        interaction;
      logic        calibrated;
      logic        screen_up_negative;
   } rsp_type;

   typedef struct packed {
      logic [14:0] shake_threshold;
      logic [14:0] dominant_z_threshold;
      logic [14:0] flat_axis_threshold;
      logic [14:0] wake_z_threshold;
      logic [15:0] shake_cooldown_ms;
      logic [15:0] dizzy_duration_ms;
      logic [15:0] face_down_hold_ms;
      logic [15:0] face_up_hold_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shake_threshold:      15'd4301,
      dominant_z_threshold: 15'd3195,
      flat_axis_threshold:  15'd1720,
      wake_z_threshold:     15'd1843,
      shake_cooldown_ms:    16'd1800,
      dizzy_duration_ms:    16'd2200,
      face_down_hold_ms:    16'd450,
      face_up_hold_ms:      16'd180
   };

   // sample as seen by the state update stage
   typedef struct packed {
      logic signed [15:0] accel_z;
      logic [15:0]        mag_x;
      logic [15:0]        mag_y;
      logic [15:0]        mag_z;
      logic [31:0]        now_ms;
      logic               external_wake;
      logic               big_change;
   } motion_type;

   // magnitude of a 16-bit value, -32768 gives 32768
   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      mag16 = v[15] ? (~v + 16'd1) : v;
   endfunction

endpackage

@@ hw/rtl/sfd_delta.sv @@
module sfd_delta
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   input  logic [14:0] shake_threshold,
   output logic        out_valid,
   input  logic        out_ready,
   output motion_type  out_data
);

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [15:0]       s1_z_ff;
   logic [31:0]              s1_now_ff;
   logic                     s1_wake_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic                     s1_pv_ff;
   logic [15:0]              s1_mx_ff, s1_my_ff, s1_mz_ff;

   logic signed [15:0]       prev_x_ff, prev_y_ff, prev_z_ff;
   logic                     prev_valid_ff;
   logic [TSQ_W-1:0]         tsq_ff;

   logic                     in_take;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [31:0]              sq_x, sq_y, sq_z;
   logic [DSQ_W-1:0]         dsq;

   assign in_ready    = !s1_valid_ff || out_ready;
   assign in_take     = in_valid && in_ready;
   assign s1_valid_in = in_take || (s1_valid_ff && !out_ready);

   // difference against the previous accepted transaction
   assign dx_in = {in_data.accel_x[15], in_data.accel_x} - {prev_x_ff[15], prev_x_ff};
   assign dy_in = {in_data.accel_y[15], in_data.accel_y} - {prev_y_ff[15], prev_y_ff};
   assign dz_in = {in_data.accel_z[15], in_data.accel_z} - {prev_z_ff[15], prev_z_ff};

   // each square is below 2^32
   assign sq_x = s1_dx_ff * s1_dx_ff;
   assign sq_y = s1_dy_ff * s1_dy_ff;
   assign sq_z = s1_dz_ff * s1_dz_ff;
   assign dsq  = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (in_take) begin
            prev_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tsq_ff <= shake_threshold * shake_threshold;
      if (in_take) begin
         prev_x_ff  <= in_data.accel_x;
         prev_y_ff  <= in_data.accel_y;
         prev_z_ff  <= in_data.accel_z;
         s1_z_ff    <= in_data.accel_z;
         s1_now_ff  <= in_data.now_ms;
         s1_wake_ff <= in_data.external_wake;
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_dz_ff   <= dz_in;
         s1_pv_ff   <= prev_valid_ff;
         s1_mx_ff   <= mag16(in_data.accel_x);
         s1_my_ff   <= mag16(in_data.accel_y);
         s1_mz_ff   <= mag16(in_data.accel_z);
      end
   end

   assign out_valid              = s1_valid_ff;
   assign out_data.accel_z       = s1_z_ff;
   assign out_data.mag_x         = s1_mx_ff;
   assign out_data.mag_y         = s1_my_ff;
   assign out_data.mag_z         = s1_mz_ff;
   assign out_data.now_ms        = s1_now_ff;
   assign out_data.external_wake = s1_wake_ff;
   assign out_data.big_change    = s1_pv_ff &&
                                   (dsq >= {{(DSQ_W-TSQ_W){1'b0}}, tsq_ff});

endmodule

@@ hw/rtl/shake_and_face_down_detector_top.sv @@
// channel   ports                          payload    transaction when
// request   req_valid req_stall req_data   req_type   req_valid && !req_stall
// response  rsp_valid rsp_stall rsp_data   rsp_type   rsp_valid && !rsp_stall
// config    csr_wr_en csr_addr csr_wdata   16 bits    csr_wr_en
//
// one transaction per cycle sustained while rsp_stall is low; a request goes
// into the input register holding the differences, then square sum, threshold
// compare and state update are combinational into the result register.
// reset is synchronous and restores the default thresholds and clears state.
// while rsp_stall holds a result, an empty input register keeps taking
// transactions; req_stall rises only once both stages are full.
module shake_and_face_down_detector_top
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type     cfg_ff;
   logic        mo_valid, mo_ready, req_ready, st_take;
   motion_type  mo;

   logic        cal_ff, cal_in;
   logic        neg_ff, neg_in;
   logic        sleep_ff, sleep_in;
   logic [31:0] last_shake_ff, last_shake_in;
   logic [31:0] dizzy_ff, dizzy_in;
   logic [31:0] down_cand_ff, down_cand_in;
   logic [31:0] up_cand_ff, up_cand_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic               sleep_w;
   logic               flat_now, down_now, up_now, shake;
   logic               entered, cleared;
   logic signed [16:0] z17, dzt17, wzt17;
   logic [31:0]        since_shake, since_down, since_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_SHAKE_THRESHOLD:      cfg_ff.shake_threshold      <= csr_wdata[14:0];
            CSR_DOMINANT_Z_THRESHOLD: cfg_ff.dominant_z_threshold <= csr_wdata[14:0];
            CSR_FLAT_AXIS_THRESHOLD:  cfg_ff.flat_axis_threshold  <= csr_wdata[14:0];
            CSR_WAKE_Z_THRESHOLD:     cfg_ff.wake_z_threshold     <= csr_wdata[14:0];
            CSR_SHAKE_COOLDOWN_MS:    cfg_ff.shake_cooldown_ms    <= csr_wdata;
            CSR_DIZZY_DURATION_MS:    cfg_ff.dizzy_duration_ms    <= csr_wdata;
            CSR_FACE_DOWN_HOLD_MS:    cfg_ff.face_down_hold_ms    <= csr_wdata;
            CSR_FACE_UP_HOLD_MS:      cfg_ff.face_up_hold_ms      <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfd_delta u_delta (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_data         (req_data),
      .shake_threshold (cfg_ff.shake_threshold),
      .out_valid       (mo_valid),
      .out_ready       (mo_ready),
      .out_data        (mo)
   );

   assign req_stall    = !req_ready;
   assign mo_ready     = !rsp_valid_ff || !rsp_stall;
   assign st_take      = mo_valid && mo_ready;
   assign rsp_valid_in = st_take || (rsp_valid_ff && rsp_stall);

   assign z17   = {mo.accel_z[15], mo.accel_z};
   assign dzt17 = {2'b00, cfg_ff.dominant_z_threshold};
   assign wzt17 = {2'b00, cfg_ff.wake_z_threshold};

   assign since_shake = mo.now_ms - last_shake_ff;
   assign since_down  = mo.now_ms - down_cand_ff;
   assign since_up    = mo.now_ms - up_cand_ff;

   assign sleep_w  = sleep_ff && !mo.external_wake;
   assign flat_now = (mo.mag_z >= {1'b0, cfg_ff.dominant_z_threshold}) &&
                     (mo.mag_x <= FLAT_CAL_LIMIT) && (mo.mag_y <= FLAT_CAL_LIMIT);
   assign shake    = mo.big_change && !sleep_w &&
                     (since_shake >= {16'd0, cfg_ff.shake_cooldown_ms});

   // orientation is judged with the sign fixed by this transaction, if any
   always_comb begin
      cal_in = cal_ff;
      neg_in = neg_ff;
      if (!cal_ff && flat_now) begin
         cal_in = 1'b1;
         neg_in = mo.accel_z[15];
      end
      if (neg_in) begin
         down_now = z17 >= dzt17;
         up_now   = z17 <= wzt17;
      end else begin
         down_now = z17 <= -dzt17;
         up_now   = z17 >= -wzt17;
      end
      down_now = down_now && (mo.mag_x <= {1'b0, cfg_ff.flat_axis_threshold}) &&
                 (mo.mag_y <= {1'b0, cfg_ff.flat_axis_threshold});
   end

   always_comb begin
      sleep_in      = sleep_w;
      dizzy_in      = mo.external_wake ? 32'd0 : dizzy_ff;
      last_shake_in = last_shake_ff;
      down_cand_in  = down_cand_ff;
      up_cand_in    = up_cand_ff;
      entered       = 1'b0;
      cleared       = 1'b0;
      if (shake) begin
         last_shake_in = mo.now_ms;
         dizzy_in      = mo.now_ms + {16'd0, cfg_ff.dizzy_duration_ms};
      end
      if (cal_in) begin
         if (!sleep_w) begin
            if (down_now) begin
               if (down_cand_ff == 32'd0) begin
                  down_cand_in = mo.now_ms;
               end else if (since_down >= {16'd0, cfg_ff.face_down_hold_ms}) begin
                  sleep_in     = 1'b1;
                  dizzy_in     = 32'd0;
                  down_cand_in = 32'd0;
                  up_cand_in   = 32'd0;
                  entered      = 1'b1;
               end
            end else begin
               down_cand_in = 32'd0;
            end
         end else if (up_now) begin
            if (up_cand_ff == 32'd0) begin
               up_cand_in = mo.now_ms;
            end else if (since_up >= {16'd0, cfg_ff.face_up_hold_ms}) begin
               sleep_in     = 1'b0;
               up_cand_in   = 32'd0;
               down_cand_in = 32'd0;
               cleared      = 1'b1;
            end
         end else begin
            up_cand_in = 32'd0;
         end
      end
   end

   always_comb begin
      rsp_data_in.shake_detected     = shake;
      rsp_data_in.dizzy_until_ms     = dizzy_in;
      rsp_data_in.face_down_sleep    = sleep_in;
      rsp_data_in.sleep_entered      = entered;
      rsp_data_in.sleep_cleared      = cleared;
      rsp_data_in.interaction        = shake || cleared;
      rsp_data_in.calibrated         = cal_in;
      rsp_data_in.screen_up_negative = neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff        <= 1'b0;
         neg_ff        <= 1'b0;
         sleep_ff      <= 1'b0;
         last_shake_ff <= 32'd0;
         dizzy_ff      <= 32'd0;
         down_cand_ff  <= 32'd0;
         up_cand_ff    <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (st_take) begin
            cal_ff        <= cal_in;
            neg_ff        <= neg_in;
            sleep_ff      <= sleep_in;
            last_shake_ff <= last_shake_in;
            dizzy_ff      <= dizzy_in;
            down_cand_ff  <= down_cand_in;
            up_cand_ff    <= up_cand_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with an empty result register");

   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      cal_ff |=> cal_ff)
      else $error("calibration lost without reset");

   a_enter_clears_dizzy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.sleep_entered |->
         rsp_data_ff.face_down_sleep && (rsp_data_ff.dizzy_until_ms == 32'd0))
      else $error("sleep entry left dizzy deadline or sleep flag wrong");

   a_sleep_edges_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.sleep_entered && rsp_data_ff.sleep_cleared) &&
         !(rsp_data_ff.shake_detected && rsp_data_ff.sleep_cleared))
      else $error("conflicting sleep and shake flags");

   a_state_moves_with_result: assert property (@(posedge clock) disable iff (reset)
      !st_take |=> $stable(sleep_ff) && $stable(dizzy_ff) && $stable(last_shake_ff))
      else $error("detector state changed without a transaction");

endmodule
